// ----- design/vocm_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the color key overlay mixer.
// No dependencies; imported by the mixer top level.
package vocm_pkg;

   localparam int FRAME_DEPTH_DEF = 131072;
   localparam int MAX_LINE        = 1024;
   localparam int FRAC_BITS       = 12;
   localparam int POS_W           = 34;
   localparam int STEP_W          = 22;
   localparam int INDEX_W         = 17;
   localparam int RGB_W           = 24;
   localparam int PAL_DEPTH       = 256;
   localparam int PAL_AW          = 8;
   localparam int COUNT_W         = 12;
   localparam int VWIDTH_W        = 11;
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic [RGB_W-1:0] ERR_COLOR = 24'hFF0000;

   typedef enum logic [1:0] {
      CMD_PAL_WR = 2'd0,
      CMD_VID_WR = 2'd1,
      CMD_FRAME  = 2'd2,
      CMD_PIXEL  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      MIX_GFX   = 2'd0,
      MIX_KEY   = 2'd1,
      MIX_VIDEO = 2'd2
   } mix_type;

   typedef enum logic [2:0] {
      REG_MIX_MODE    = 3'd0,
      REG_PIXEL_FMT   = 3'd1,
      REG_KEY_INDEX   = 3'd2,
      REG_LINE_WIDTH  = 3'd3,
      REG_VIDEO_WIDTH = 3'd4,
      REG_COLUMN_STEP = 3'd5,
      REG_ROW_STEP    = 3'd6
   } reg_idx_type;

endpackage

// ----- design/vocm_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vocm_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/video_overlay_color_key_mixer.sv -----
`timescale 1ns / 1ps
// Color key overlay mixer: palette, frame store, scaled video fetch and mixing.
// Depends on vocm_pkg and vocm_ram.
// A pixel beat passes through stages 1 to 4 and then the output register before its result shows.
// Throughput: one beat per cycle unless rsp_tready stalls the pipe; the frame store read port
// and the row-base multiplier each serve one beat a cycle through a four-stage pipeline.
// Reset: after reset is released a clearing pass writes black into all
// FRAME_DEPTH frame store entries and zero into the palette, one entry a cycle;
// req_tready stays low until the pass ends. FRAME_DEPTH must be a power of two (not checked).
module video_overlay_color_key_mixer
   import vocm_pkg::*;
#(
   parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,  // index[16:0], red[24:17], green[32:25],
                                             // blue[40:33], zero[47:41]
   input  logic [1:0]            req_tuser,  // command[1:0]
   // Result channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
   output logic                  rsp_tlast,  // line_end
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int ADDR_W = $clog2(FRAME_DEPTH);

   // Configuration registers.
   logic [1:0]          mix_mode_ff;
   logic                pixel_fmt_ff;
   logic [PAL_AW-1:0]   key_index_ff;
   logic [COUNT_W-1:0]  line_width_ff;
   logic [VWIDTH_W-1:0] video_width_ff;
   logic [STEP_W-1:0]   column_step_ff;
   logic [STEP_W-1:0]   row_step_ff;

   logic        csr_wr;
   reg_idx_type csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = reg_idx_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         mix_mode_ff    <= MIX_GFX;
         pixel_fmt_ff   <= 1'b0;
         key_index_ff   <= '0;
         line_width_ff  <= 12'd320;
         video_width_ff <= 11'd320;
         column_step_ff <= 22'd4096;
         row_step_ff    <= 22'd4096;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MIX_MODE:    mix_mode_ff    <= csr_pwdata[1:0];
            REG_PIXEL_FMT:   pixel_fmt_ff   <= csr_pwdata[0];
            REG_KEY_INDEX:   key_index_ff   <= csr_pwdata[PAL_AW-1:0];
            REG_LINE_WIDTH:  line_width_ff  <= csr_pwdata[COUNT_W-1:0];
            REG_VIDEO_WIDTH: video_width_ff <= csr_pwdata[VWIDTH_W-1:0];
            REG_COLUMN_STEP: column_step_ff <= csr_pwdata[STEP_W-1:0];
            REG_ROW_STEP:    row_step_ff    <= csr_pwdata[STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MIX_MODE:    csr_prdata = CSR_DATA_W'(mix_mode_ff);
         REG_PIXEL_FMT:   csr_prdata = CSR_DATA_W'(pixel_fmt_ff);
         REG_KEY_INDEX:   csr_prdata = CSR_DATA_W'(key_index_ff);
         REG_LINE_WIDTH:  csr_prdata = CSR_DATA_W'(line_width_ff);
         REG_VIDEO_WIDTH: csr_prdata = CSR_DATA_W'(video_width_ff);
         REG_COLUMN_STEP: csr_prdata = CSR_DATA_W'(column_step_ff);
         REG_ROW_STEP:    csr_prdata = CSR_DATA_W'(row_step_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // Clearing pass after reset.
   logic              clearing_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic              clr_pal;

   assign clr_pal = (clr_cnt_ff[ADDR_W-1:PAL_AW] == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_cnt_ff  <= '0;
      end else if (clearing_ff) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == {ADDR_W{1'b1}}) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   // Pipeline flow control: a stage loads when it is empty or moves on.
   logic s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, rsp_v_ff;
   logic en1, en2, en3, en4, en_out;

   assign en_out     = !rsp_v_ff || rsp_tready;
   assign en4        = !s4_v_ff || en_out;
   assign en3        = !s3_v_ff || en4;
   assign en2        = !s2_v_ff || en3;
   assign en1        = !s1_v_ff || en2;
   assign req_tready = en1 && !clearing_ff;

   // Stage 1: input register, line position state.
   cmd_type            s1_cmd_ff;
   logic [INDEX_W-1:0] s1_idx_ff;
   logic [RGB_W-1:0]   s1_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (en1) begin
         s1_v_ff <= req_tvalid && req_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         s1_cmd_ff <= cmd_type'(req_tuser);
         s1_idx_ff <= req_tdata[16:0];
         s1_rgb_ff <= {req_tdata[24:17], req_tdata[32:25], req_tdata[40:33]};
      end
   end

   logic [COUNT_W-1:0]  col_cnt_ff, col_cnt_in;
   logic [POS_W-1:0]    col_pos_ff, col_pos_in;
   logic [POS_W-1:0]    row_pos_ff, row_pos_in;
   // Video width in force when the current row began; with the row number it
   // gives the row base address.
   logic [VWIDTH_W-1:0] row_vw_ff, row_vw_in;
   logic                s1_go;
   logic                s1_last;
   logic                s1_keyed;

   assign s1_go   = s1_v_ff && en2;
   assign s1_last = ({1'b0, col_cnt_ff} + 13'd1) >= {1'b0, line_width_ff};
   assign s1_keyed = pixel_fmt_ff ? (s1_rgb_ff == '0) : (s1_idx_ff[PAL_AW-1:0] == key_index_ff);

   always_comb begin
      col_cnt_in = col_cnt_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      row_vw_in  = row_vw_ff;
      if (s1_go) begin
         case (s1_cmd_ff)
            CMD_FRAME: begin
               col_cnt_in = '0;
               col_pos_in = '0;
               row_pos_in = '0;
            end
            CMD_PIXEL: begin
               if (s1_last) begin
                  col_cnt_in = '0;
                  col_pos_in = '0;
                  row_pos_in = row_pos_ff + POS_W'(row_step_ff);
                  row_vw_in  = video_width_ff;
               end else begin
                  col_cnt_in = col_cnt_ff + 1'b1;
                  col_pos_in = col_pos_ff + POS_W'(column_step_ff);
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         row_vw_ff  <= '0;
      end else begin
         col_cnt_ff <= col_cnt_in;
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         row_vw_ff  <= row_vw_in;
      end
   end

   // Palette: written from stage 1, read data lines up with stage 2.
   logic              pal_wr_en;
   logic [PAL_AW-1:0] pal_wr_addr;
   logic [RGB_W-1:0]  pal_wr_data;
   logic [RGB_W-1:0]  pal_rd_data;

   assign pal_wr_en   = clearing_ff ? clr_pal : (s1_go && s1_cmd_ff == CMD_PAL_WR);
   assign pal_wr_addr = clearing_ff ? clr_cnt_ff[PAL_AW-1:0] : s1_idx_ff[PAL_AW-1:0];
   assign pal_wr_data = clearing_ff ? '0 : s1_rgb_ff;

   vocm_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PAL_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (pal_wr_data),
      .rd_en   (s1_go),
      .rd_addr (s1_idx_ff[PAL_AW-1:0]),
      .rd_data (pal_rd_data)
   );

   // Stage 2: row base multiply and graphics color.
   logic [INDEX_W+ADDR_W-1:0] s1_idx_ext;
   assign s1_idx_ext = {{ADDR_W{1'b0}}, s1_idx_ff};

   cmd_type                       s2_cmd_ff;
   logic [ADDR_W-1:0]             s2_waddr_ff;
   logic [RGB_W-1:0]              s2_rgb_ff;
   logic                          s2_keyed_ff;
   logic                          s2_last_ff;
   logic [POS_W-FRAC_BITS-1:0]    s2_row_ff;
   logic [VWIDTH_W-1:0]           s2_rvw_ff;
   logic [ADDR_W-1:0]             s2_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (en2) begin
         s2_v_ff <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_waddr_ff <= s1_idx_ext[ADDR_W-1:0];
         s2_rgb_ff   <= s1_rgb_ff;
         s2_keyed_ff <= s1_keyed;
         s2_last_ff  <= s1_last;
         s2_row_ff   <= row_pos_ff[POS_W-1:FRAC_BITS];
         s2_rvw_ff   <= row_vw_ff;
         s2_col_ff   <= col_pos_ff[FRAC_BITS +: ADDR_W];
      end
   end

   logic [VWIDTH_W+POS_W-FRAC_BITS-1:0] s2_prod;
   logic [RGB_W-1:0]                    s2_gfx;

   assign s2_prod = (VWIDTH_W+POS_W-FRAC_BITS)'(s2_rvw_ff)
                  * (VWIDTH_W+POS_W-FRAC_BITS)'(s2_row_ff);
   assign s2_gfx  = pixel_fmt_ff ? s2_rgb_ff : pal_rd_data;

   // Stage 3: frame store address and access.
   cmd_type           s3_cmd_ff;
   logic [ADDR_W-1:0] s3_waddr_ff;
   logic [RGB_W-1:0]  s3_rgb_ff;
   logic [RGB_W-1:0]  s3_gfx_ff;
   logic              s3_keyed_ff;
   logic              s3_last_ff;
   logic [ADDR_W-1:0] s3_base_ff;
   logic [ADDR_W-1:0] s3_col_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else if (en3) begin
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         s3_cmd_ff   <= s2_cmd_ff;
         s3_waddr_ff <= s2_waddr_ff;
         s3_rgb_ff   <= s2_rgb_ff;
         s3_gfx_ff   <= s2_gfx;
         s3_keyed_ff <= s2_keyed_ff;
         s3_last_ff  <= s2_last_ff;
         s3_base_ff  <= s2_prod[ADDR_W-1:0];
         s3_col_ff   <= s2_col_ff;
      end
   end

   // Writes and reads of the frame store both happen here, so they keep
   // the order of the beats.
   logic              frm_wr_en;
   logic [ADDR_W-1:0] frm_wr_addr;
   logic [RGB_W-1:0]  frm_wr_data;
   logic [ADDR_W-1:0] frm_rd_addr;
   logic [RGB_W-1:0]  frm_rd_data;

   assign frm_wr_en   = clearing_ff || (s3_v_ff && en4 && s3_cmd_ff == CMD_VID_WR);
   assign frm_wr_addr = clearing_ff ? clr_cnt_ff : s3_waddr_ff;
   assign frm_wr_data = clearing_ff ? '0 : s3_rgb_ff;
   assign frm_rd_addr = s3_base_ff + s3_col_ff;

   vocm_ram #(
      .WIDTH (RGB_W),
      .DEPTH (FRAME_DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (frm_wr_en),
      .wr_addr (frm_wr_addr),
      .wr_data (frm_wr_data),
      .rd_en   (en4),
      .rd_addr (frm_rd_addr),
      .rd_data (frm_rd_data)
   );

   // Stage 4: mixing.
   logic [RGB_W-1:0] s4_gfx_ff;
   logic             s4_keyed_ff;
   logic             s4_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_v_ff <= 1'b0;
      end else if (en4) begin
         s4_v_ff <= s3_v_ff && (s3_cmd_ff == CMD_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         s4_gfx_ff   <= s3_gfx_ff;
         s4_keyed_ff <= s3_keyed_ff;
         s4_last_ff  <= s3_last_ff;
      end
   end

   logic [RGB_W-1:0] s4_res;

   always_comb begin
      if ({1'b0, line_width_ff} > (COUNT_W+1)'(MAX_LINE)) begin
         s4_res = ERR_COLOR;
      end else begin
         case (mix_type'(mix_mode_ff))
            MIX_VIDEO: s4_res = frm_rd_data;
            MIX_KEY:   s4_res = s4_keyed_ff ? frm_rd_data : s4_gfx_ff;
            default:   s4_res = s4_gfx_ff;
         endcase
      end
   end

   // Output register.
   logic [RGB_W-1:0] rsp_rgb_ff;
   logic             rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (en_out) begin
         rsp_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         rsp_rgb_ff  <= s4_res;
         rsp_last_ff <= s4_last_ff;
      end
   end

   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = {rsp_rgb_ff[7:0], rsp_rgb_ff[15:8], rsp_rgb_ff[23:16]};
   assign rsp_tlast  = rsp_last_ff;

   // Checks.
   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_tready)
      else $error("input accepted during the frame store clearing pass");

   a_pipe_empty_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !(s1_v_ff || s2_v_ff || s3_v_ff || s4_v_ff))
      else $error("pipeline holds a beat during the clearing pass");

   a_column_origin: assert property (@(posedge clock) disable iff (reset)
      (col_cnt_ff == '0) |-> (col_pos_ff == '0))
      else $error("column position not at origin at the start of a line");

   a_result_from_pixel: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_v_ff) |-> $past(s4_v_ff))
      else $error("result appeared without a pixel in the mixing stage");

endmodule

// ----- verif/vocm_mix_checker.sv -----
`timescale 1ns / 1ps
// Checker for the color key overlay mixer: tracks register writes, keeps its own palette,
// frame store and scan position, and compares every result beat with its prediction.
// Depends on vocm_pkg.
module vocm_mix_checker
   import vocm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [47:0]           req_tdata,  // index[16:0], red[24:17], green[32:25],
                                             // blue[40:33], zero[47:41]
   input  logic [1:0]            req_tuser,  // command[1:0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [23:0]           rsp_tdata,  // out_red[7:0], out_green[15:8], out_blue[23:16]
   input  logic                  rsp_tlast,  // line_end
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    open_pixels
);

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       line_end;
   } mixed_pixel_type;

   mixed_pixel_type   mixed_pixels_q[$];
   logic [RGB_W-1:0]  palette_mem [PAL_DEPTH];
   logic [RGB_W-1:0]  video_mem [FRAME_DEPTH_DEF];

   logic [1:0]          cfg_mix;
   logic                cfg_direct;
   logic [7:0]          cfg_key;
   logic [COUNT_W-1:0]  cfg_line_width;
   logic [VWIDTH_W-1:0] cfg_video_width;
   logic [STEP_W-1:0]   cfg_col_step;
   logic [STEP_W-1:0]   cfg_row_step;

   logic [COUNT_W-1:0]  col_count;
   logic [POS_W-1:0]    col_pos;
   logic [POS_W-1:0]    row_pos;
   logic [INDEX_W-1:0]  row_base;

   int errors = 0;

   always @(posedge clock) begin : track
      logic [INDEX_W-1:0] idx;
      logic [INDEX_W-1:0] addr;
      logic [RGB_W-1:0]   rgb, gfx, vid, res;
      logic               keyed, last;
      logic [63:0]        prod;
      mixed_pixel_type    got, want;
      if (reset) begin
         foreach (palette_mem[i]) palette_mem[i] = '0;
         foreach (video_mem[i]) video_mem[i] = '0;
         mixed_pixels_q.delete();
         cfg_mix         = MIX_GFX;
         cfg_direct      = 1'b0;
         cfg_key         = '0;
         cfg_line_width  = 12'd320;
         cfg_video_width = 11'd320;
         cfg_col_step    = 22'd4096;
         cfg_row_step    = 22'd4096;
         col_count       = '0;
         col_pos         = '0;
         row_pos         = '0;
         row_base        = '0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_idx_type'(csr_paddr[CSR_ADDR_W-1:2]))
               REG_MIX_MODE:    cfg_mix         = csr_pwdata[1:0];
               REG_PIXEL_FMT:   cfg_direct      = csr_pwdata[0];
               REG_KEY_INDEX:   cfg_key         = csr_pwdata[7:0];
               REG_LINE_WIDTH:  cfg_line_width  = csr_pwdata[COUNT_W-1:0];
               REG_VIDEO_WIDTH: cfg_video_width = csr_pwdata[VWIDTH_W-1:0];
               REG_COLUMN_STEP: cfg_col_step    = csr_pwdata[STEP_W-1:0];
               REG_ROW_STEP:    cfg_row_step    = csr_pwdata[STEP_W-1:0];
               default: ;
            endcase
         end

         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tlast};
            if (mixed_pixels_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result beat: expected none, %s %02h%02h%02h last %b",
                        $time, "actual rgb", got.red, got.green, got.blue, got.line_end);
            end else begin
               want = mixed_pixels_q.pop_front();
               if (got !== want) begin
                  errors++;
                  $display("%0t: pixel mismatch: expected rgb %02h%02h%02h last %b,",
                           $time, want.red, want.green, want.blue, want.line_end);
                  $display("%0t:   actual rgb %02h%02h%02h last %b",
                           $time, got.red, got.green, got.blue, got.line_end);
               end
            end
         end

         if (req_tvalid && req_tready) begin
            idx = req_tdata[16:0];
            rgb = {req_tdata[24:17], req_tdata[32:25], req_tdata[40:33]};
            case (cmd_type'(req_tuser))
               CMD_PAL_WR: palette_mem[idx[PAL_AW-1:0]] = rgb;
               // The store is exactly 2**17 deep, so the address wraps by itself.
               CMD_VID_WR: video_mem[idx] = rgb;
               CMD_FRAME: begin
                  col_count = '0;
                  col_pos   = '0;
                  row_pos   = '0;
                  row_base  = '0;
               end
               CMD_PIXEL: begin
                  if (cfg_direct) begin
                     gfx   = rgb;
                     keyed = (rgb == '0);
                  end else begin
                     gfx   = palette_mem[idx[PAL_AW-1:0]];
                     keyed = (idx[PAL_AW-1:0] == cfg_key);
                  end
                  addr = row_base + INDEX_W'(col_pos >> FRAC_BITS);
                  vid  = video_mem[addr];
                  if (cfg_line_width > MAX_LINE)
                     res = ERR_COLOR;
                  else if (cfg_mix == MIX_VIDEO)
                     res = vid;
                  else if (cfg_mix == MIX_KEY)
                     res = keyed ? vid : gfx;
                  else
                     res = gfx;
                  last = (int'(col_count) + 1 >= int'(cfg_line_width));
                  want = {res, last};
                  mixed_pixels_q.push_back(want);
                  if (last) begin
                     col_count = '0;
                     col_pos   = '0;
                     row_pos   = row_pos + POS_W'(cfg_row_step);
                     prod      = 64'(cfg_video_width) * 64'(row_pos >> FRAC_BITS);
                     row_base  = prod[INDEX_W-1:0];
                  end else begin
                     col_count = col_count + 1'b1;
                     col_pos   = col_pos + POS_W'(cfg_col_step);
                  end
               end
               default: ;
            endcase
         end
      end
      fail_count  <= errors;
      open_pixels <= mixed_pixels_q.size();
   end

endmodule

// ----- verif/video_overlay_color_key_mixer_test.sv -----
`timescale 1ns / 1ps
// Top of the overlay mixer testbench: clock, reset, stimulus, receiver stalls and verdict.
// Depends on vocm_pkg, the mixer RTL and vocm_mix_checker.
module video_overlay_color_key_mixer_test;
   import vocm_pkg::*;

   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 400000;
   localparam int PHASES         = 12;
   localparam int PHASE_BEATS    = 110;
   localparam int LONG_HOLD      = 400;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [47:0]           req_tdata;  // index[16:0], red[24:17], green[32:25],
                                      // blue[40:33], zero[47:41]
   logic [1:0]            req_tuser;  // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;  // out_red[7:0], out_green[15:8], out_blue[23:16]
   logic                  rsp_tlast;  // line_end
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int fail_count;
   int open_pixels;
   int quiet_cycles = 0;

   bit req_steady   = 1'b0;
   bit rsp_steady   = 1'b0;
   int rsp_hold_len = 0;

   always #5ns clock = ~clock;

   video_overlay_color_key_mixer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   vocm_mix_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .open_pixels (open_pixels)
   );

   // The clearing pass after reset is the longest quiet stretch a correct run has.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Result side: a random stall before each beat, or one long hold when asked for.
   initial begin : receiver
      int unsigned stall;
      rsp_tready = 1'b0;
      forever begin
         if (rsp_hold_len != 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (rsp_hold_len) @(negedge clock);
            rsp_hold_len = 0;
         end
         stall = rsp_steady ? 0 : $urandom_range(0, 3);
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   task automatic csr_write(input reg_idx_type which, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {which, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic write_all_regs(input logic [1:0] mix, input logic direct,
                                 input logic [7:0] key, input logic [11:0] line_w,
                                 input logic [10:0] video_w, input logic [21:0] col_step,
                                 input logic [21:0] row_step);
      csr_write(REG_MIX_MODE, 32'(mix));
      csr_write(REG_PIXEL_FMT, 32'(direct));
      csr_write(REG_KEY_INDEX, 32'(key));
      csr_write(REG_LINE_WIDTH, 32'(line_w));
      csr_write(REG_VIDEO_WIDTH, 32'(video_w));
      csr_write(REG_COLUMN_STEP, 32'(col_step));
      csr_write(REG_ROW_STEP, 32'(row_step));
   endtask

   task automatic push_beat(input cmd_type cmd, input logic [16:0] idx,
                            input logic [23:0] rgb);
      int unsigned gap;
      gap = req_steady ? 0 : $urandom_range(0, 3);
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {7'd0, rgb[7:0], rgb[15:8], rgb[23:16], idx};
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits until every expected pixel is back; writes alone may still be in flight,
   // so the task then waits out a settling stretch before any register changes.
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (open_pixels != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [21:0] pick_step();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return 22'h3FFFFF;
         2:       return 22'($urandom);
         default: return 22'($urandom_range(512, 12288));
      endcase
   endfunction

   initial begin : stimulus
      int unsigned sel;
      logic [1:0]  mix;
      logic        direct;
      logic [7:0]  key;
      logic [11:0] line_w;
      logic [10:0] video_w;
      logic [16:0] idx;
      logic [23:0] rgb;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_PAL_WR;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // Let the clearing pass finish before touching the registers.
      do @(posedge clock); while (!req_tready);

      // Keyed palette mode on a tiny picture, three pixels per line, two video rows per line.
      write_all_regs(MIX_KEY, 1'b0, 8'h00, 12'd3, 11'd4, 22'd4096, 22'd8192);
      push_beat(CMD_PAL_WR, 17'h00000, 24'h123456);
      push_beat(CMD_PAL_WR, 17'h1FFFF, 24'hFFFFFF);
      push_beat(CMD_VID_WR, 17'h00000, 24'h0A0B0C);
      push_beat(CMD_VID_WR, 17'h00001, 24'h202122);
      push_beat(CMD_VID_WR, 17'h1FFFF, 24'hFFFFFF);
      push_beat(CMD_VID_WR, 17'h00008, 24'h808080);
      push_beat(CMD_FRAME, 17'h1FFFF, 24'hFFFFFF);
      push_beat(CMD_PIXEL, 17'h00000, 24'h000000);
      push_beat(CMD_PIXEL, 17'h1FFFF, 24'h000000);
      push_beat(CMD_PIXEL, 17'h1FF00, 24'hFFFFFF);
      push_beat(CMD_PIXEL, 17'h00000, 24'h000000);
      push_beat(CMD_PIXEL, 17'h00001, 24'h000000);
      settle();

      // Zero line width ends every line; mode 3 falls back to graphics only.
      csr_write(REG_LINE_WIDTH, 32'd0);
      csr_write(REG_MIX_MODE, 32'd3);
      csr_write(REG_PIXEL_FMT, 32'd1);
      push_beat(CMD_PIXEL, 17'h00000, 24'h000000);
      push_beat(CMD_PIXEL, 17'h1FFFF, 24'hFFFFFF);
      settle();

      // A line wider than MAX_LINE turns every pixel red.
      csr_write(REG_MIX_MODE, 32'(MIX_VIDEO));
      csr_write(REG_LINE_WIDTH, 32'd1025);
      csr_write(REG_COLUMN_STEP, 32'h003FFFFF);
      csr_write(REG_ROW_STEP, 32'h003FFFFF);
      push_beat(CMD_PIXEL, 17'h00005, 24'h000000);
      push_beat(CMD_PIXEL, 17'h00006, 24'h00FF00);
      settle();

      csr_write(REG_MIX_MODE, 32'(MIX_KEY));
      csr_write(REG_LINE_WIDTH, 32'd1024);
      csr_write(REG_VIDEO_WIDTH, 32'd1024);
      push_beat(CMD_FRAME, 17'h00000, 24'h000000);
      push_beat(CMD_PIXEL, 17'h00000, 24'h000000);
      push_beat(CMD_PIXEL, 17'h00000, 24'hA5A5A5);
      push_beat(CMD_PIXEL, 17'h00000, 24'h000000);
      settle();

      for (int ph = 0; ph < PHASES; ph++) begin
         mix    = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
         direct = 1'($urandom);
         key    = 8'($urandom);
         case ($urandom_range(0, 9))
            0:       line_w = 12'd0;
            1:       line_w = 12'd1024;
            2:       line_w = 12'($urandom_range(1025, 4094));
            3:       line_w = 12'd4095;
            default: line_w = 12'($urandom_range(1, 40));
         endcase
         case ($urandom_range(0, 7))
            0:       video_w = 11'd1;
            1:       video_w = 11'd1024;
            default: video_w = 11'($urandom_range(2, 64));
         endcase
         write_all_regs(mix, direct, key, line_w, video_w, pick_step(), pick_step());

         req_steady = (ph % 4 == 2) || (ph == 5);
         rsp_steady = (ph % 4 == 2);
         // Hold the result side off while the sender keeps offering, so the block backs up.
         if (ph == 5) rsp_hold_len = LONG_HOLD;

         push_beat(CMD_FRAME, 17'($urandom), 24'($urandom));
         for (int n = 0; n < PHASE_BEATS; n++) begin
            sel = $urandom_range(0, 99);
            idx = 17'($urandom);
            rgb = 24'($urandom);
            if (sel < 3) begin
               push_beat(CMD_FRAME, idx, rgb);
            end else if (sel < 11) begin
               push_beat(CMD_PAL_WR, idx, rgb);
            end else if (sel < 25) begin
               // Most picture writes land where a small picture is read back.
               if ($urandom_range(0, 7) != 0) idx = 17'($urandom_range(0, 4095));
               push_beat(CMD_VID_WR, idx, rgb);
            end else begin
               if ($urandom_range(0, 2) == 0) idx[7:0] = key;
               if ($urandom_range(0, 3) == 0) rgb = '0;
               push_beat(CMD_PIXEL, idx, rgb);
            end
         end
         settle();
         req_steady = 1'b0;
         rsp_steady = 1'b0;
      end

      if (fail_count == 0 && open_pixels == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

// ----- sim.f -----
design/vocm_pkg.sv
design/vocm_ram.sv
design/video_overlay_color_key_mixer.sv
verif/vocm_mix_checker.sv
verif/video_overlay_color_key_mixer_test.sv
